// ===== src/lane_marking_ridge_filter_unit_defines.svh =====
// Assertion macros shared by the checker of the lane marking ridge filter.
`ifndef LANE_MARKING_RIDGE_FILTER_UNIT_DEFINES_SVH
`define LANE_MARKING_RIDGE_FILTER_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define LMRF_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define LMRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lmrf_pkg.sv =====
// Shared types and constants of the lane marking ridge filter.
package lmrf_pkg;

  localparam int PIX_W      = 8;
  localparam int SPAN_W     = 6;
  localparam int WIDTH_W    = 13;
  localparam int COL_W      = 12;
  localparam int EXTRA_W    = 7;
  localparam int MAX_WIDTH  = 4096;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_SPAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd1;

  localparam logic [SPAN_W-1:0]  HALF_SPAN_RST = 6'd18;
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST = 13'd640;

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_PTR_W = 2;
  localparam int JOBQ_CNT_W = 3;

  // One classified input item: its lagged column result and the flush that follows.
  typedef struct packed {
    logic [PIX_W-1:0]   mark;
    logic               has_main;
    logic               ends;
    logic [EXTRA_W-1:0] extra;
  } job_t;

  // Occupancy of the job queue as seen by the front and the back.
  typedef struct packed {
    logic [JOBQ_CNT_W-1:0] count;
    logic                  empty;
  } jobq_stat_t;

endpackage

// ===== src/lmrf_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module lmrf_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DATA_W-1:0]        rdata_a,
  output logic [DATA_W-1:0]        rdata_b
);

  logic [DATA_W-1:0] mem_r [DEPTH];

  // Write and registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// ===== src/lmrf_front.sv =====
// Front end: configuration, column tracking, delay line and response arithmetic.
module lmrf_front #(
  parameter int MAX_SPAN = 63
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [lmrf_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [lmrf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lmrf_pkg::PIX_W-1:0]         in_tdata,
  input  lmrf_pkg::jobq_stat_t               q_stat,
  output logic                               push,
  output lmrf_pkg::job_t                     push_job
);
  import lmrf_pkg::*;

  localparam int DELAY_DEPTH = 2 * MAX_SPAN + 1;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int RAM_DEPTH   = 1 << ADDR_W;
  localparam int FILL_W      = $clog2(RAM_DEPTH + 1);
  localparam int OFS_W       = SPAN_W + 1;
  localparam int CMP_W       = ((FILL_W > OFS_W) ? FILL_W : OFS_W) + 1;
  localparam int SPAN_CAP    = (MAX_SPAN < 63) ? MAX_SPAN : 63;

  logic [SPAN_W-1:0]  half_span_r;
  logic [WIDTH_W-1:0] row_width_r;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ADDR_W-1:0]  wp_r;
  logic [FILL_W-1:0]  fill_r;

  logic [SPAN_W-1:0]  tau;
  logic [OFS_W-1:0]   tau2;
  logic [WIDTH_W-1:0] w_eff;
  logic               in_fire;
  logic               ends, has_main, interior, c_ok, l_ok;
  logic [EXTRA_W-1:0] extra;
  logic [JOBQ_CNT_W-1:0] occ;
  logic [ADDR_W-1:0]  rd_c, rd_l;
  logic [PIX_W-1:0]   ram_c, ram_l;

  logic               s1_valid_r;
  logic               s1_has_main_r, s1_ends_r, s1_interior_r;
  logic [EXTRA_W-1:0] s1_extra_r;
  logic [PIX_W-1:0]   s1_pix_r;
  logic               s1_byp_r, s1_c_ok_r, s1_l_ok_r;

  logic [PIX_W-1:0]   cv, lv, rv, maxlr, diff, mark;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_span_r <= HALF_SPAN_RST;
      row_width_r <= ROW_WIDTH_RST;
    end else if (cfg_wr_en) begin
      if (cfg_addr == REG_HALF_SPAN) begin
        half_span_r <= cfg_wdata[SPAN_W-1:0];
      end else if (cfg_addr == REG_ROW_WIDTH) begin
        row_width_r <= cfg_wdata[WIDTH_W-1:0];
      end
    end
  end

  // Effective span and row width after saturation.
  assign tau  = (half_span_r > SPAN_W'(SPAN_CAP)) ? SPAN_W'(SPAN_CAP) : half_span_r;
  assign tau2 = {tau, 1'b0};
  always_comb begin
    if (row_width_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (row_width_r > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = row_width_r;
    end
  end

  // Accept only while the queue can take every item already in flight.
  assign occ       = q_stat.count + JOBQ_CNT_W'(s1_valid_r);
  assign in_tready = occ < JOBQ_CNT_W'(JOBQ_DEPTH);
  assign in_fire   = in_tvalid && in_tready;

  // Classify the item by its column.
  assign ends     = {1'b0, col_r} >= (w_eff - WIDTH_W'(1));
  assign has_main = col_r >= COL_W'(tau);
  assign interior = (col_r >= COL_W'(tau2)) && ({1'b0, col_r} < w_eff);
  assign extra    = !ends ? '0 :
                    has_main ? EXTRA_W'(tau) : (EXTRA_W'(col_r) + EXTRA_W'(1));
  assign col_nxt  = ends ? '0 : col_r + COL_W'(1);

  // Neighbors older than the fill level have never been written and read as zero.
  assign c_ok = CMP_W'(tau) <= CMP_W'(fill_r);
  assign l_ok = CMP_W'(tau2) <= CMP_W'(fill_r);
  assign rd_c = wp_r - ADDR_W'(tau);
  assign rd_l = wp_r - ADDR_W'(tau2);

  lmrf_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (RAM_DEPTH)
  ) u_delay (
    .clk     (clk),
    .we      (in_fire),
    .waddr   (wp_r),
    .wdata   (in_tdata),
    .raddr_a (rd_c),
    .raddr_b (rd_l),
    .rdata_a (ram_c),
    .rdata_b (ram_l)
  );

  // Column counter, write pointer and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      wp_r   <= '0;
      fill_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      wp_r  <= wp_r + ADDR_W'(1);
      if (fill_r != FILL_W'(RAM_DEPTH)) begin
        fill_r <= fill_r + FILL_W'(1);
      end
    end
  end

  // Stage one holds the item while the delay line is read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire && (has_main || ends);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_has_main_r <= has_main;
      s1_ends_r     <= ends;
      s1_interior_r <= interior;
      s1_extra_r    <= extra;
      s1_pix_r      <= in_tdata;
      s1_byp_r      <= (tau == '0);
      s1_c_ok_r     <= c_ok;
      s1_l_ok_r     <= l_ok;
    end
  end

  // With a span of zero all three taps are the new pixel itself.
  assign rv = s1_pix_r;
  assign cv = s1_byp_r ? s1_pix_r : (s1_c_ok_r ? ram_c : '0);
  assign lv = s1_byp_r ? s1_pix_r : (s1_l_ok_r ? ram_l : '0);

  // 2c - l - r - |l - r| equals 2 * (c - max(l, r)); a zero center never exceeds the max.
  assign maxlr = (lv > rv) ? lv : rv;
  assign diff  = cv - maxlr;
  always_comb begin
    if (!s1_interior_r || (cv <= maxlr)) begin
      mark = '0;
    end else if (diff[PIX_W-1]) begin
      mark = '1;
    end else begin
      mark = {diff[PIX_W-2:0], 1'b0};
    end
  end

  assign push              = s1_valid_r;
  assign push_job.mark     = mark;
  assign push_job.has_main = s1_has_main_r;
  assign push_job.ends     = s1_ends_r;
  assign push_job.extra    = s1_extra_r;

endmodule

// ===== src/lmrf_job_fifo.sv =====
// Short job queue between the front end and the result sequencer.
module lmrf_job_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lmrf_pkg::job_t       push_job,
  input  logic                 pop,
  output lmrf_pkg::job_t       head,
  output lmrf_pkg::jobq_stat_t stat
);
  import lmrf_pkg::*;

  job_t                  slot_r [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOBQ_CNT_W-1:0] count_r;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + JOBQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + JOBQ_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + JOBQ_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - JOBQ_CNT_W'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);

endmodule

// ===== src/lmrf_back.sv =====
// Back end: expands each job into its results and drives the output register.
module lmrf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lmrf_pkg::jobq_stat_t       q_stat,
  input  lmrf_pkg::job_t             head,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [lmrf_pkg::PIX_W-1:0] out_tdata,
  output logic                       out_tlast,
  output logic                       out_tuser
);
  import lmrf_pkg::*;

  logic               cur_valid_r, cur_valid_nxt;
  logic               cur_main_r, cur_main_nxt;
  logic               cur_ends_r, cur_ends_nxt;
  logic [EXTRA_W-1:0] cur_left_r, cur_left_nxt;
  logic [PIX_W-1:0]   cur_mark_r, cur_mark_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_mark_r, out_mark_nxt;
  logic               out_rend_r, out_rend_nxt;
  logic               out_last_r, out_last_nxt;

  logic               load_ok, emit, finishing;

  // One result leaves the current job whenever the output register is free.
  assign load_ok   = !out_valid_r || out_tready;
  assign emit      = cur_valid_r && load_ok;
  assign finishing = cur_main_r ? (cur_left_r == '0) : (cur_left_r == EXTRA_W'(1));
  assign pop       = !q_stat.empty && (!cur_valid_r || (emit && finishing));

  // Next state of the job and output registers.
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_main_nxt  = cur_main_r;
    cur_ends_nxt  = cur_ends_r;
    cur_left_nxt  = cur_left_r;
    cur_mark_nxt  = cur_mark_r;
    out_valid_nxt = out_valid_r;
    out_mark_nxt  = out_mark_r;
    out_rend_nxt  = out_rend_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_mark_nxt  = cur_main_r ? cur_mark_r : '0;
      out_last_nxt  = finishing;
      out_rend_nxt  = finishing && cur_ends_r;
      if (cur_main_r) begin
        cur_main_nxt = 1'b0;
      end else begin
        cur_left_nxt = cur_left_r - EXTRA_W'(1);
      end
      if (finishing) begin
        cur_valid_nxt = 1'b0;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_main_nxt  = head.has_main;
      cur_ends_nxt  = head.ends;
      cur_left_nxt  = head.extra;
      cur_mark_nxt  = head.mark;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_main_r <= cur_main_nxt;
    cur_ends_r <= cur_ends_nxt;
    cur_left_r <= cur_left_nxt;
    cur_mark_r <= cur_mark_nxt;
    out_mark_r <= out_mark_nxt;
    out_rend_r <= out_rend_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mark_r;
  assign out_tlast  = out_rend_r;
  assign out_tuser  = out_last_r;

endmodule

// ===== src/lane_marking_ridge_filter_unit.sv =====
// Lane marking ridge filter top level: front end, job queue and result sequencer.
// Results pass stage one, the job queue, the current job and the output register.
// One pixel per cycle while the queue has room; a pixel that ends a row yields
// 1 + min(column, span) results, which the output register issues one per cycle while out_tready is high.
// Reset (rst_n, synchronous, active low) empties the pipeline and queue, sets
// half_span to 18 and row_width to 640, and makes the delay line read as zeros.
module lane_marking_ridge_filter_unit #(
  parameter int MAX_SPAN = 63
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [lmrf_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [lmrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lmrf_pkg::PIX_W-1:0]      in_tdata,   // [7:0] pixel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lmrf_pkg::PIX_W-1:0]      out_tdata,  // [7:0] marking
  output logic                            out_tlast,  // row_end
  output logic                            out_tuser   // [0] last
);
  import lmrf_pkg::*;

  logic       push, pop;
  job_t       push_job, head;
  jobq_stat_t q_stat;

  lmrf_front #(
    .MAX_SPAN (MAX_SPAN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  lmrf_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  lmrf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== src/lmrf_checker.sv =====
// Port-level checks of the lane marking ridge filter and their binding.
`include "lane_marking_ridge_filter_unit_defines.svh"

module lmrf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [lmrf_pkg::PIX_W-1:0] out_tdata,
  input logic                       out_tlast,
  input logic                       out_tuser
);

  // A stalled result keeps its marking and flags.
  `LMRF_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")

  // The end of a row is always the final result of the pixel that ends it.
  `LMRF_ASSERT_RUN(a_row_end_last, out_tvalid && out_tlast |-> out_tuser, "row end without last flag")

  // Reset empties the output register on the following edge.
  `LMRF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind lane_marking_ridge_filter_unit lmrf_checker u_lmrf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
